>>> design/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define RSS_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at an edge outside reset
`define RSS_NEVER(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> design/rss_pkg.sv
package rss_pkg;

	localparam int LEN_W = 16;
	localparam int RND_W = 32;
	localparam int CAP_W = 9;
	localparam int RATE_W = 17;
	localparam int PERIOD_W = 10;
	localparam int BYTES_W = 24;
	localparam int CNT_W = 32;
	localparam int FED_W = 48;
	localparam int SLOT_OUT_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [1:0] REQ_FEED = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;
	localparam logic [1:0] REQ_STATS = 2'd2;

	localparam logic [1:0] CMD_IGNORE = 2'd0;
	localparam logic [1:0] CMD_FEED = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_STATS = 2'd3;

	localparam logic [1:0] MODE_RANDOM = 2'd0;
	localparam logic [1:0] MODE_SYSTEMATIC = 2'd1;
	localparam logic [1:0] MODE_STRATIFIED = 2'd2;
	localparam logic [1:0] MODE_RESERVOIR = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEEP_RATE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd3;

	localparam logic [RATE_W-1:0] RATE_MIN = 17'd66;
	localparam logic [RATE_W-1:0] RATE_MAX = 17'd65536;
	localparam logic [PERIOD_W-1:0] PERIOD_MIN = 10'd1;
	localparam logic [PERIOD_W-1:0] PERIOD_MAX = 10'd1000;
	localparam logic [BYTES_W-1:0] BYTES_MAX = 24'hFFFFFF;

	typedef struct packed {
		logic [1:0] req_type;
		logic [LEN_W-1:0] record_length;
		logic [RND_W-1:0] random_word;
	} in_item_t;

	typedef struct packed {
		logic collected;
		logic replaced;
		logic evicted;
		logic reservoir_full;
		logic [SLOT_OUT_W-1:0] slot_index;
		logic [CNT_W-1:0] sequence_number;
		logic [BYTES_W-1:0] stored_bytes;
		logic [CAP_W-1:0] stored_count;
		logic [CNT_W-1:0] collected_total;
		logic [CNT_W-1:0] evicted_total;
		logic [CNT_W-1:0] replacement_total;
		logic [FED_W-1:0] bytes_fed_total;
	} result_t;

	typedef struct packed {
		logic [1:0] kind;
		logic rate_keep;
		logic [LEN_W-1:0] record_length;
		logic [RND_W-1:0] random_word;
	} cmd_t;

endpackage

>>> design/rss_front.sv
module rss_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input rss_pkg::in_item_t item,
	input logic [rss_pkg::RATE_W-1:0] keep_rate,
	output logic cmd_valid,
	input logic cmd_pop,
	output rss_pkg::cmd_t cmd
);
	import rss_pkg::*;

	cmd_t entry_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	cmd_t new_cmd;
	logic do_push;
	logic do_pop;

	always_comb begin
		new_cmd.record_length = item.record_length;
		new_cmd.random_word = item.random_word;
		new_cmd.rate_keep = ({1'b0, item.random_word[31:16]} <= keep_rate);
		unique case (item.req_type)
			REQ_FEED: new_cmd.kind = (item.record_length != '0) ? CMD_FEED : CMD_IGNORE;
			REQ_CLEAR: new_cmd.kind = CMD_CLEAR;
			REQ_STATS: new_cmd.kind = CMD_STATS;
			default: new_cmd.kind = CMD_IGNORE;
		endcase
	end

	assign full = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = entry_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

>>> design/rss_outq.sv
module rss_outq (
	input logic clk,
	input logic arst_n,
	input logic res_push,
	input rss_pkg::result_t res_data,
	output logic res_full,
	output logic empty,
	input logic pop,
	output rss_pkg::result_t result
);
	import rss_pkg::*;

	result_t entry_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign res_full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign result = entry_q[rd_q];
	assign do_push = res_push && !res_full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= res_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

>>> design/rss_back.sv
module rss_back #(
	parameter int SLOTS = 256
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_pop,
	input rss_pkg::cmd_t cmd,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [rss_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [rss_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic [rss_pkg::RATE_W-1:0] keep_rate,
	output logic res_push,
	output rss_pkg::result_t res_data,
	input logic res_full
);
	import rss_pkg::*;
	`include "assert_macros.svh"

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CAP_MAX = (SLOTS < 511) ? SLOTS : 511;
	localparam int CAP_RST = (SLOTS < 256) ? SLOTS : 256;
	localparam logic [CAP_W-1:0] CAP_MAX_V = CAP_W'(CAP_MAX);
	localparam logic [CAP_W-1:0] CAP_RST_V = CAP_W'(CAP_RST);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DECIDE = 3'd1;
	localparam logic [2:0] ST_MUL = 3'd2;
	localparam logic [2:0] ST_JCHK = 3'd3;
	localparam logic [2:0] ST_APPLY = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	function automatic logic [CAP_W-1:0] ring_add(logic [CAP_W-1:0] a, logic [CAP_W-1:0] b,
			logic [CAP_W-1:0] cap);
		logic [CAP_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, cap}) begin
			s = s - {1'b0, cap};
		end
		return s[CAP_W-1:0];
	endfunction

	function automatic logic [BYTES_W-1:0] bytes_sub(logic [BYTES_W-1:0] b, logic [LEN_W-1:0] n);
		logic [BYTES_W-1:0] nx;
		nx = BYTES_W'(n);
		return (b > nx) ? (b - nx) : '0;
	endfunction

	function automatic logic [BYTES_W-1:0] bytes_add(logic [BYTES_W-1:0] b, logic [LEN_W-1:0] n);
		logic [BYTES_W:0] s;
		s = {1'b0, b} + (BYTES_W + 1)'(n);
		return s[BYTES_W] ? BYTES_MAX : s[BYTES_W-1:0];
	endfunction

	// configuration
	logic [1:0] mode_q;
	logic [CAP_W-1:0] cap_q;
	logic [RATE_W-1:0] rate_q;
	logic [PERIOD_W-1:0] period_q;

	// store and statistics
	logic [LEN_W-1:0] slot_len_q [SLOTS];
	logic [LEN_W-1:0] rdata_q;
	logic [CAP_W-1:0] oldest_q;
	logic [CAP_W-1:0] occ_q;
	logic [CNT_W-1:0] feed_q;
	logic [PERIOD_W-1:0] cdown_q;
	logic [BYTES_W-1:0] bsum_q;
	logic [CNT_W-1:0] kept_q;
	logic [CNT_W-1:0] drop_q;
	logic [CNT_W-1:0] swap_q;
	logic [FED_W-1:0] fedb_q;

	// item in progress
	logic [2:0] st_q;
	cmd_t cmd_q;
	logic [2*CNT_W-1:0] prod_q;
	logic col_q;
	logic rep_q;
	logic ev_q;
	logic full_q;
	logic [CAP_W-1:0] slot_q;
	logic [CNT_W-1:0] seq_q;

	logic store_full;
	logic do_keep;
	logic do_evict;
	logic do_mul;
	logic j_hit;
	logic [CAP_W-1:0] tail_slot;
	logic [CAP_W-1:0] rep_slot;
	logic mem_we;
	logic mem_re;
	logic [IW-1:0] mem_waddr;
	logic [IW-1:0] mem_raddr;
	logic [CAP_W-1:0] cfg_cap;
	logic [RATE_W-1:0] cfg_rate;
	logic [PERIOD_W-1:0] cfg_period;

	assign cfg_ready = 1'b1;
	assign keep_rate = rate_q;
	assign cmd_pop = (st_q == ST_IDLE) && cmd_valid && !res_full;
	assign res_push = (st_q == ST_DONE);

	assign store_full = (occ_q >= cap_q);
	assign tail_slot = ring_add(oldest_q, occ_q, cap_q);
	assign rep_slot = ring_add(oldest_q, prod_q[CNT_W +: CAP_W], cap_q);
	assign j_hit = (prod_q[2*CNT_W-1:CNT_W] < CNT_W'(cap_q));

	always_comb begin
		do_mul = 1'b0;
		unique case (mode_q)
			MODE_SYSTEMATIC: do_keep = (cdown_q == '0);
			MODE_RESERVOIR: begin
				do_keep = !store_full;
				do_mul = store_full;
			end
			default: do_keep = cmd_q.rate_keep;
		endcase
		do_evict = do_keep && store_full;
	end

	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_waddr = IW'(tail_slot);
		mem_raddr = IW'(oldest_q);
		unique case (st_q)
			ST_DECIDE: begin
				if (cmd_q.kind == CMD_FEED) begin
					mem_re = do_evict;
					mem_we = do_keep && !do_evict;
				end
			end
			ST_JCHK: begin
				mem_re = j_hit;
				mem_raddr = IW'(rep_slot);
			end
			ST_APPLY: begin
				mem_we = 1'b1;
				mem_waddr = IW'(slot_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_len_q[mem_waddr] <= cmd_q.record_length;
		end
		if (mem_re) begin
			rdata_q <= slot_len_q[mem_raddr];
		end
	end

	always_comb begin
		cfg_cap = cfg_data[CAP_W-1:0];
		if (cfg_cap == '0) begin
			cfg_cap = CAP_W'(1);
		end else if (cfg_cap > CAP_MAX_V) begin
			cfg_cap = CAP_MAX_V;
		end
		cfg_rate = cfg_data[RATE_W-1:0];
		if (cfg_rate < RATE_MIN) begin
			cfg_rate = RATE_MIN;
		end else if (cfg_rate > RATE_MAX) begin
			cfg_rate = RATE_MAX;
		end
		cfg_period = cfg_data[PERIOD_W-1:0];
		if (cfg_period < PERIOD_MIN) begin
			cfg_period = PERIOD_MIN;
		end else if (cfg_period > PERIOD_MAX) begin
			cfg_period = PERIOD_MAX;
		end
	end

	always_comb begin
		res_data.collected = col_q;
		res_data.replaced = rep_q;
		res_data.evicted = ev_q;
		res_data.reservoir_full = full_q;
		res_data.slot_index = slot_q[SLOT_OUT_W-1:0];
		res_data.sequence_number = seq_q;
		res_data.stored_bytes = bsum_q;
		res_data.stored_count = occ_q;
		res_data.collected_total = kept_q;
		res_data.evicted_total = drop_q;
		res_data.replacement_total = swap_q;
		res_data.bytes_fed_total = fedb_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RANDOM;
			cap_q <= CAP_RST_V;
			rate_q <= RATE_MAX;
			period_q <= PERIOD_MIN;
			oldest_q <= '0;
			occ_q <= '0;
			feed_q <= '0;
			cdown_q <= '0;
			bsum_q <= '0;
			kept_q <= '0;
			drop_q <= '0;
			swap_q <= '0;
			fedb_q <= '0;
			st_q <= ST_IDLE;
			cmd_q <= '0;
			prod_q <= '0;
			col_q <= 1'b0;
			rep_q <= 1'b0;
			ev_q <= 1'b0;
			full_q <= 1'b0;
			slot_q <= '0;
			seq_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						cmd_q <= cmd;
						col_q <= 1'b0;
						rep_q <= 1'b0;
						ev_q <= 1'b0;
						full_q <= 1'b0;
						slot_q <= '0;
						seq_q <= '0;
						st_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					unique case (cmd_q.kind)
						CMD_CLEAR: begin
							occ_q <= '0;
							oldest_q <= '0;
							feed_q <= '0;
							cdown_q <= '0;
							bsum_q <= '0;
							st_q <= ST_DONE;
						end
						CMD_STATS: begin
							kept_q <= '0;
							drop_q <= '0;
							swap_q <= '0;
							fedb_q <= '0;
							bsum_q <= '0;
							st_q <= ST_DONE;
						end
						CMD_FEED: begin
							fedb_q <= fedb_q + FED_W'(cmd_q.record_length);
							feed_q <= feed_q + CNT_W'(1);
							seq_q <= feed_q + CNT_W'(1);
							if (mode_q == MODE_SYSTEMATIC) begin
								cdown_q <= do_keep ? (period_q - PERIOD_W'(1))
									: (cdown_q - PERIOD_W'(1));
							end
							priority if (do_evict) begin
								col_q <= 1'b1;
								ev_q <= 1'b1;
								slot_q <= oldest_q;
								st_q <= ST_APPLY;
							end else if (do_keep) begin
								col_q <= 1'b1;
								slot_q <= tail_slot;
								occ_q <= occ_q + CAP_W'(1);
								bsum_q <= bytes_add(bsum_q, cmd_q.record_length);
								kept_q <= kept_q + CNT_W'(1);
								full_q <= (mode_q == MODE_RESERVOIR)
									&& (({1'b0, occ_q} + 10'd1) >= {1'b0, cap_q});
								st_q <= ST_DONE;
							end else if (do_mul) begin
								st_q <= ST_MUL;
							end else begin
								st_q <= ST_DONE;
							end
						end
						default: begin
							st_q <= ST_DONE;
						end
					endcase
				end
				ST_MUL: begin
					prod_q <= (2*CNT_W)'(feed_q) * (2*CNT_W)'(cmd_q.random_word);
					st_q <= ST_JCHK;
				end
				ST_JCHK: begin
					if (j_hit) begin
						rep_q <= 1'b1;
						slot_q <= rep_slot;
						st_q <= ST_APPLY;
					end else begin
						st_q <= ST_DONE;
					end
				end
				ST_APPLY: begin
					bsum_q <= bytes_add(bytes_sub(bsum_q, rdata_q), cmd_q.record_length);
					if (ev_q) begin
						oldest_q <= ring_add(oldest_q, CAP_W'(1), cap_q);
						drop_q <= drop_q + CNT_W'(1);
						kept_q <= kept_q + CNT_W'(1);
					end else begin
						swap_q <= swap_q + CNT_W'(1);
					end
					st_q <= ST_DONE;
				end
				ST_DONE: begin
					st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase

			if (cfg_valid) begin
				unique case (cfg_index)
					REG_MODE: begin
						mode_q <= cfg_data[1:0];
						feed_q <= '0;
					end
					REG_CAPACITY: begin
						cap_q <= cfg_cap;
						occ_q <= '0;
						oldest_q <= '0;
						feed_q <= '0;
						cdown_q <= '0;
						bsum_q <= '0;
					end
					REG_KEEP_RATE: rate_q <= cfg_rate;
					REG_PERIOD: period_q <= cfg_period;
				endcase
			end
		end
	end

	`RSS_ASSERT(a_occ_in_cap, clk, arst_n, occ_q <= cap_q, "occupied count above capacity")
	`RSS_ASSERT(a_oldest_in_cap, clk, arst_n, oldest_q < cap_q, "oldest slot outside ring")
	`RSS_NEVER(a_push_room, clk, arst_n, res_push && res_full, "result pushed into full queue")
	`RSS_ASSERT(a_write_in_cap, clk, arst_n, mem_we |-> (CAP_W'(mem_waddr) < cap_q),
		"slot write outside ring")

endmodule

>>> design/record_sampling_selector.sv
// record sampling selector
// input: an item {req_type, record_length, random_word} transfers when push is high
// and full is low; req_type selects feed, clear store or reset statistics.
// results: one result per input item, in order; the oldest waiting result sits on
// result while empty is low and transfers when pop is high.
// config: cfg_index/cfg_data transfer when cfg_valid is high (cfg_ready is always
// high); write only while no item is in flight.
// path from input transfer to result: clear, statistics reset, ignored items and
// plain appends pass decide and done; an append that evicts adds an update; a
// reservoir decision adds multiply, slot index check, then on a hit slot length
// read and update. one shared sequencer works one item at a time to its result;
// a two-entry input queue and a two-entry result queue let either side
// stall on its own. when pop stays low the result queue fills and the sequencer
// stops taking items, then full rises once the input queue holds two items.
// reset: both queues empty, store empty, all totals zero, mode random,
// capacity 256 (or the slot count if smaller), keep rate 65536, period 1.
module record_sampling_selector #(
	parameter int SLOTS = 256
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input rss_pkg::in_item_t item,
	output logic empty,
	input logic pop,
	output rss_pkg::result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [rss_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [rss_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rss_pkg::*;

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;
	logic [RATE_W-1:0] keep_rate;
	result_t res_data;
	logic res_push;
	logic res_full;

	rss_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.keep_rate(keep_rate),
		.cmd_valid(cmd_valid),
		.cmd_pop(cmd_pop),
		.cmd(cmd)
	);

	rss_back #(
		.SLOTS(SLOTS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_pop(cmd_pop),
		.cmd(cmd),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.keep_rate(keep_rate),
		.res_push(res_push),
		.res_data(res_data),
		.res_full(res_full)
	);

	rss_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.res_push(res_push),
		.res_data(res_data),
		.res_full(res_full),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

endmodule
